FILE: design/cdso_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the CD sector to image offset mapper.
package cdso_pkg;

    // Field widths
    localparam int SECTOR_W    = 24;
    localparam int POS_W       = 32;
    localparam int SIZE_W      = 12;
    localparam int SKIP_W      = 5;
    localparam int FILE_W      = 4;
    localparam int SLOT_W      = 7;
    localparam int BUF_W       = 16;
    localparam int OUT_POS_W   = 36;
    localparam int STATUS_W    = 2;
    localparam int TCOUNT_W    = 8;
    localparam int FCOUNT_W    = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // Track search is split into groups of this many lanes
    localparam int GROUP       = 16;
    localparam int GRP_W       = 4;

    // Number of image files the block supports; larger counts clamp to it
    localparam int MAX_FILES   = 16;
    localparam int FLIM_W      = 7;

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_TRACK     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FILE_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LOADED       = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_SECTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_SKIP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] FLAT_SECTOR_RESET = 12'd2048;

    typedef struct packed {
        logic [SECTOR_W-1:0] start;
        logic [POS_W-1:0]    position;
        logic [SIZE_W-1:0]   sector_bytes;
        logic [SKIP_W-1:0]   skip_bytes;
        logic                audio;
        logic [FILE_W-1:0]   file;
    } track_entry_t;

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        track_entry_t        entry;
        logic [SECTOR_W-1:0] sector;
        logic [BUF_W-1:0]    buffer_bytes;
    } item_t;

    typedef struct packed {
        logic [TCOUNT_W-1:0] track_count;
        logic [FCOUNT_W-1:0] file_count;
        logic [SIZE_W-1:0]   flat_sector_bytes;
        logic [SKIP_W-1:0]   flat_skip_bytes;
        logic                swap_enable;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [FILE_W-1:0]   file;
        logic [SIZE_W-1:0]   count;
        logic                swap;
        logic [SKIP_W-1:0]   skip;
        logic [POS_W-1:0]    base;
    } result_ctl_t;

endpackage

FILE: design/cdso_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module cdso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/cdso_search.sv
`timescale 1ns / 1ps
// Track start table and three-stage search for the first track holding a sector.
module cdso_search import cdso_pkg::*; #(
    parameter int TRACKS = 128,
    parameter int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [TCOUNT_W-1:0] track_count,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output item_t               out_item,
    output logic                out_found,
    output logic [IDX_W-1:0]    out_idx
);

    localparam int NG   = (TRACKS + GROUP - 1) / GROUP;
    localparam int NG_W = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD  = NG * GROUP;

    // Start sector of each track, one compare lane per entry
    logic [SECTOR_W-1:0] start_reg [TRACKS];

    logic [8:0]        count_lim;
    logic [TRACKS-1:0] lane_take;
    logic [TRACKS-1:0] lane_after;
    logic [TRACKS-1:0] lane_hit;
    logic              load_write;

    // Stage registers
    logic              v1_reg, v2_reg, v3_reg;
    item_t             item1_reg, item2_reg, item3_reg;
    logic [TRACKS-1:0] hit1_reg;
    logic [NG-1:0]     any2_reg;
    logic [NG-1:0][GRP_W-1:0] loc2_reg;
    logic              found3_reg;
    logic [IDX_W-1:0]  idx3_reg;

    logic [PAD-1:0]           hit_pad;
    logic [NG-1:0]            any_next;
    logic [NG-1:0][GRP_W-1:0] loc_next;
    logic                     found_next;
    logic [NG_W-1:0]          sel_grp;
    logic [GRP_W-1:0]         sel_loc;
    logic [IDX_W-1:0]         idx_next;

    logic en1, en2, en3;

    // Stage advance: a stage loads when empty or when its successor moves
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Write the start table when a load is transferred
    assign load_write = in_valid && in_ready && (in_item.op == OP_LOAD) &&
                        (9'(in_item.slot) < 9'(TRACKS));

    always_ff @(posedge aclk) begin
        if (load_write) begin
            start_reg[IDX_W'(in_item.slot)] <= in_item.entry.start;
        end
    end

    // Compare the request against every lane in parallel
    always_comb begin
        count_lim = (9'(track_count) > 9'(TRACKS)) ? 9'(TRACKS) : 9'(track_count);
        for (int i = 0; i < TRACKS; i++) begin
            lane_take[i] = (9'(i) < count_lim) && (in_item.sector >= start_reg[i]);
        end
        lane_after = lane_take >> 1;
        lane_hit   = lane_take & ~lane_after;
    end

    // Stage 1: hit vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            item1_reg <= in_item;
            hit1_reg  <= lane_hit;
        end
    end

    // Find the first hit inside each group
    always_comb begin
        hit_pad  = PAD'(hit1_reg);
        any_next = '0;
        loc_next = '0;
        for (int g = 0; g < NG; g++) begin
            for (int j = GROUP - 1; j >= 0; j--) begin
                if (hit_pad[g * GROUP + j]) begin
                    any_next[g] = 1'b1;
                    loc_next[g] = GRP_W'(j);
                end
            end
        end
    end

    // Stage 2: per-group results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            item2_reg <= item1_reg;
            any2_reg  <= any_next;
            loc2_reg  <= loc_next;
        end
    end

    // Pick the first group that holds a hit
    always_comb begin
        found_next = 1'b0;
        sel_grp    = '0;
        sel_loc    = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (any2_reg[g]) begin
                found_next = 1'b1;
                sel_grp    = NG_W'(g);
                sel_loc    = loc2_reg[g];
            end
        end
        idx_next = IDX_W'({sel_grp, sel_loc});
    end

    // Stage 3: matching entry index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            item3_reg  <= item2_reg;
            found3_reg <= found_next;
            idx3_reg   <= idx_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;
    assign out_found = found3_reg;
    assign out_idx   = idx3_reg;

endmodule

FILE: design/cdso_calc.sv
`timescale 1ns / 1ps
// Track entry store and the offset arithmetic: entry read, decode, multiply, add.
module cdso_calc import cdso_pkg::*; #(
    parameter int TRACKS = 128,
    parameter int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  item_t                in_item,
    input  logic                 in_found,
    input  logic [IDX_W-1:0]     in_idx,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic                 m_track_hit,
    output logic [SLOT_W-1:0]    m_track_slot,
    output logic [FILE_W-1:0]    m_file_select,
    output logic [OUT_POS_W-1:0] m_byte_position,
    output logic [SIZE_W-1:0]    m_byte_count,
    output logic                 m_swap_pairs
);

    localparam int EW = $bits(track_entry_t);

    logic en4, en5, en6, en7;

    logic              ram_wr_en;
    logic [EW-1:0]     ram_rd_data;
    track_entry_t      entry4;

    // Stage registers
    logic              v4_reg, v5_reg, v6_reg, v7_reg;
    item_t             item4_reg;
    logic              found4_reg;
    logic [IDX_W-1:0]  idx4_reg;
    result_ctl_t       ctl5_reg, ctl6_reg;
    logic [SECTOR_W-1:0] mula5_reg;
    logic [SIZE_W-1:0]   mulb5_reg;
    logic [OUT_POS_W-1:0] prod6_reg;

    logic [STATUS_W-1:0]  status_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [FILE_W-1:0]    file_reg;
    logic [OUT_POS_W-1:0] pos_reg;
    logic [SIZE_W-1:0]    count_reg;
    logic                 swap_reg;

    // Decode signals
    logic [FLIM_W-1:0]   files_lim;
    logic [SIZE_W-1:0]   size;
    logic [SKIP_W-1:0]   skip_row;
    logic                short_read;
    logic [SIZE_W-1:0]   count;
    logic [SECTOR_W-1:0] diff;
    logic                file_missing;
    result_ctl_t         ctl_next;
    logic [SECTOR_W-1:0] mula_next;
    logic [SIZE_W-1:0]   mulb_next;
    logic [OUT_POS_W-1:0] prod_next;
    logic [OUT_POS_W-1:0] pos_next;

    // Stage advance: a stage loads when empty or when its successor moves
    assign en7      = !v7_reg || m_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    // Loads write the entry store at the same stage lookups read it
    assign ram_wr_en = in_valid && en4 && (in_item.op == OP_LOAD) &&
                       (9'(in_item.slot) < 9'(TRACKS));

    cdso_ram #(
        .WIDTH (EW),
        .DEPTH (TRACKS),
        .AW    (IDX_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(in_item.slot)),
        .wr_data (in_item.entry),
        .rd_en   (en4),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    assign entry4 = track_entry_t'(ram_rd_data);

    // Stage 4: entry read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4 && in_valid) begin
            item4_reg  <= in_item;
            found4_reg <= in_found;
            idx4_reg   <= in_idx;
        end
    end

    // Decode the case and set up the multiplier operands
    always_comb begin
        files_lim = ({2'b0, cfg.file_count} > FLIM_W'(MAX_FILES)) ?
                    FLIM_W'(MAX_FILES) : {2'b0, cfg.file_count};
        size       = found4_reg ? entry4.sector_bytes : cfg.flat_sector_bytes;
        skip_row   = found4_reg ? entry4.skip_bytes : cfg.flat_skip_bytes;
        short_read = {4'b0, size} > item4_reg.buffer_bytes;
        count      = short_read ? item4_reg.buffer_bytes[SIZE_W-1:0] : size;
        diff       = item4_reg.sector - entry4.start;
        file_missing = (files_lim != '0) && ({3'b0, entry4.file} >= files_lim);

        ctl_next  = '0;
        mula_next = '0;
        mulb_next = '0;
        if (item4_reg.op == OP_LOAD) begin
            ctl_next.status = STATUS_LOADED;
        end else if (!found4_reg) begin
            if (files_lim > FLIM_W'(1)) begin
                ctl_next.status = STATUS_NO_TRACK;
            end else begin
                ctl_next.status = STATUS_OK;
                ctl_next.count  = count;
                ctl_next.skip   = short_read ? skip_row : '0;
                mula_next       = item4_reg.sector;
                mulb_next       = size;
            end
        end else if (file_missing) begin
            ctl_next.status = STATUS_FILE_MISSING;
            ctl_next.hit    = 1'b1;
            ctl_next.slot   = SLOT_W'(idx4_reg);
        end else begin
            ctl_next.status = STATUS_OK;
            ctl_next.hit    = 1'b1;
            ctl_next.slot   = SLOT_W'(idx4_reg);
            ctl_next.file   = (files_lim != '0) ? entry4.file : '0;
            ctl_next.count  = count;
            ctl_next.skip   = short_read ? skip_row : '0;
            ctl_next.swap   = cfg.swap_enable && entry4.audio && (count != '0);
            ctl_next.base   = entry4.position;
            mula_next       = diff;
            mulb_next       = size;
        end
    end

    // Stage 5: decoded item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5 && v4_reg) begin
            ctl5_reg  <= ctl_next;
            mula5_reg <= mula_next;
            mulb5_reg <= mulb_next;
        end
    end

    // Sector stride product
    assign prod_next = {12'b0, mula5_reg} * {24'b0, mulb5_reg};

    // Stage 6: product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en6) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en6 && v5_reg) begin
            ctl6_reg  <= ctl5_reg;
            prod6_reg <= prod_next;
        end
    end

    // Final byte position, wraps at the output width
    assign pos_next = {4'b0, ctl6_reg.base} + prod6_reg + OUT_POS_W'(ctl6_reg.skip);

    // Stage 7: output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en7) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en7 && v6_reg) begin
            status_reg <= ctl6_reg.status;
            hit_reg    <= ctl6_reg.hit;
            slot_reg   <= ctl6_reg.slot;
            file_reg   <= ctl6_reg.file;
            pos_reg    <= pos_next;
            count_reg  <= ctl6_reg.count;
            swap_reg   <= ctl6_reg.swap;
        end
    end

    assign m_valid         = v7_reg;
    assign m_status        = status_reg;
    assign m_track_hit     = hit_reg;
    assign m_track_slot    = slot_reg;
    assign m_file_select   = file_reg;
    assign m_byte_position = pos_reg;
    assign m_byte_count    = count_reg;
    assign m_swap_pairs    = swap_reg;

endmodule

FILE: design/cd_sector_to_image_offset_mapper.sv
`timescale 1ns / 1ps
// Top level of the CD sector to image offset mapper: configuration registers and pipeline.
//
//  Channel   Ports     Handshake        Carries
//  config    cfg_*     cfg_we only      track_count, file_count, flat geometry, swap enable
//  input     s_*       s_valid/s_ready  track entry load or sector lookup
//  result    m_*       m_valid/m_ready  status, matched track, file, position, count, swap
//
// One item enters per cycle unless a stall has filled the pipeline; a result passes through
// the lane compare, two search stages, the entry store read, decode, multiply and add.
// Every stage holds its own valid bit, so bubbles close up and a stalled result does
// not stop intake until the pipeline is full. Reset clears the valid bits and the
// configuration registers; the track table is not cleared and needs no pass.
module cd_sector_to_image_offset_mapper import cdso_pkg::*; #(
    parameter int TRACKS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [SLOT_W-1:0]     s_entry_slot,
    input  logic [SECTOR_W-1:0]   s_entry_start,
    input  logic [POS_W-1:0]      s_entry_position,
    input  logic [SIZE_W-1:0]     s_entry_sector_bytes,
    input  logic [SKIP_W-1:0]     s_entry_skip_bytes,
    input  logic                  s_entry_audio,
    input  logic [FILE_W-1:0]     s_entry_file,
    input  logic [SECTOR_W-1:0]   s_sector,
    input  logic [BUF_W-1:0]      s_buffer_bytes,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic                  m_track_hit,
    output logic [SLOT_W-1:0]     m_track_slot,
    output logic [FILE_W-1:0]     m_file_select,
    output logic [OUT_POS_W-1:0]  m_byte_position,
    output logic [SIZE_W-1:0]     m_byte_count,
    output logic                  m_swap_pairs
);

    localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    cfg_t             cfg_reg;
    item_t            in_item;
    logic             srch_valid;
    logic             srch_ready;
    item_t            srch_item;
    logic             srch_found;
    logic [IDX_W-1:0] srch_idx;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.track_count       <= '0;
            cfg_reg.file_count        <= '0;
            cfg_reg.flat_sector_bytes <= FLAT_SECTOR_RESET;
            cfg_reg.flat_skip_bytes   <= '0;
            cfg_reg.swap_enable       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TRACK_COUNT: begin
                    cfg_reg.track_count <= cfg_wdata[TCOUNT_W-1:0];
                end
                CFG_FILE_COUNT: begin
                    cfg_reg.file_count <= cfg_wdata[FCOUNT_W-1:0];
                end
                CFG_FLAT_SECTOR: begin
                    cfg_reg.flat_sector_bytes <= cfg_wdata[SIZE_W-1:0];
                end
                CFG_FLAT_SKIP: begin
                    cfg_reg.flat_skip_bytes <= cfg_wdata[SKIP_W-1:0];
                end
                CFG_SWAP_ENABLE: begin
                    cfg_reg.swap_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pack the input transfer
    assign in_item.op                 = s_op;
    assign in_item.slot               = s_entry_slot;
    assign in_item.entry.start        = s_entry_start;
    assign in_item.entry.position     = s_entry_position;
    assign in_item.entry.sector_bytes = s_entry_sector_bytes;
    assign in_item.entry.skip_bytes   = s_entry_skip_bytes;
    assign in_item.entry.audio        = s_entry_audio;
    assign in_item.entry.file         = s_entry_file;
    assign in_item.sector             = s_sector;
    assign in_item.buffer_bytes       = s_buffer_bytes;

    cdso_search #(
        .TRACKS (TRACKS),
        .IDX_W  (IDX_W)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .track_count (cfg_reg.track_count),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (in_item),
        .out_valid   (srch_valid),
        .out_ready   (srch_ready),
        .out_item    (srch_item),
        .out_found   (srch_found),
        .out_idx     (srch_idx)
    );

    cdso_calc #(
        .TRACKS (TRACKS),
        .IDX_W  (IDX_W)
    ) u_calc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (srch_valid),
        .in_ready        (srch_ready),
        .in_item         (srch_item),
        .in_found        (srch_found),
        .in_idx          (srch_idx),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_track_hit     (m_track_hit),
        .m_track_slot    (m_track_slot),
        .m_file_select   (m_file_select),
        .m_byte_position (m_byte_position),
        .m_byte_count    (m_byte_count),
        .m_swap_pairs    (m_swap_pairs)
    );

endmodule
